[hw/rtl/srgc_pkg.sv]
// Shared types, constants and helper functions for the scan ray to grid cell block.
`timescale 1ns / 1ps
`default_nettype none

package srgc_pkg;

  // Fixed-point formats
  localparam int RANGE_FRAC_BITS = 8;
  localparam int CORDIC_ITERS    = 16;
  localparam int ITER_W          = $clog2(CORDIC_ITERS);
  localparam int CELL_FB         = RANGE_FRAC_BITS + 16;   // fraction bits of x and y
  localparam int DP_W            = CELL_FB + 20;           // rotation datapath width
  localparam int R0_W            = 40;                     // prescaled radius width
  localparam int Z_W             = 24;                     // 2^24 angle units per turn
  localparam int MUL_A_W         = 32;
  localparam int MUL_B_W         = 16;
  localparam int MUL_P_W         = MUL_A_W + MUL_B_W;

  // Constants
  localparam logic [15:0]        HALF_METRE    = 16'(1 << (RANGE_FRAC_BITS - 1));
  localparam logic [15:0]        THREE_Q_METRE = 16'(3 << (RANGE_FRAC_BITS - 2));
  localparam logic [MUL_B_W-1:0] INV_GAIN      = 16'd39797;  // 1/K, Q0.16
  // intensity / 200 = ((intensity >> 3) * 41944) >> 20, exact over 16 bits
  localparam logic [MUL_B_W-1:0] CLASS_MUL     = 16'd41944;
  localparam int                 CLASS_SHIFT   = 20;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_RANGE_LIMIT = 3'd0,
    REG_ANGLE_START = 3'd1,
    REG_ANGLE_STEP  = 3'd2,
    REG_CELLS_PER_M = 3'd3,
    REG_ORIGIN_X    = 3'd4,
    REG_ORIGIN_Y    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        range_limit;
    logic signed [15:0] angle_start;
    logic [15:0]        angle_step;
    logic [15:0]        cells_per_metre;
    logic signed [15:0] origin_x_cells;
    logic signed [15:0] origin_y_cells;
  } cfg_t;

  typedef struct packed {
    logic [10:0] ray_index;
    logic [15:0] distance;
    logic [15:0] intensity;
    logic        scan_last;
  } ray_t;

  typedef struct packed {
    logic               point_valid;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic [8:0]         intensity_class;
    logic               near_hit;      // valid ray below 0.75 m
    logic               scan_done;
  } res_t;

  // CORDIC arctangent table, 2^24 units per turn
  function automatic logic signed [Z_W-1:0] atan_val(input logic [ITER_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = 24'sd2097152;
      4'd1:    v = 24'sd1238021;
      4'd2:    v = 24'sd654136;
      4'd3:    v = 24'sd332050;
      4'd4:    v = 24'sd166669;
      4'd5:    v = 24'sd83416;
      4'd6:    v = 24'sd41718;
      4'd7:    v = 24'sd20860;
      4'd8:    v = 24'sd10430;
      4'd9:    v = 24'sd5215;
      4'd10:   v = 24'sd2608;
      4'd11:   v = 24'sd1304;
      4'd12:   v = 24'sd652;
      4'd13:   v = 24'sd326;
      4'd14:   v = 24'sd163;
      4'd15:   v = 24'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Drop fraction bits toward zero, then saturate to 16 bits signed
  function automatic logic signed [15:0] to_cell(input logic signed [DP_W-1:0] s);
    logic signed [DP_W-1:0]       b;
    logic signed [DP_W-CELL_FB-1:0] q;
    logic signed [15:0]           c;
    b = s + (s[DP_W-1] ? {{(DP_W-CELL_FB){1'b0}}, {CELL_FB{1'b1}}} : '0);
    q = b[DP_W-1:CELL_FB];
    if (q[DP_W-CELL_FB-1:15] == '0 || q[DP_W-CELL_FB-1:15] == '1) begin
      c = q[15:0];
    end else if (q[DP_W-CELL_FB-1]) begin
      c = 16'sh8000;
    end else begin
      c = 16'sh7fff;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/srgc_cfg.sv]
// Configuration register file with APB-style access.
`timescale 1ns / 1ps
`default_nettype none

module srgc_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output srgc_pkg::cfg_t         cfg
);
  import srgc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t widx;
  logic     wr_en;

  assign widx  = reg_idx_t'(paddr[4:2]);
  assign wr_en = psel & penable & pwrite;

  // Register writes, access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_limit     <= 16'd65535;
      cfg_r.angle_start     <= 16'sd0;
      cfg_r.angle_step      <= 16'd0;
      cfg_r.cells_per_metre <= 16'd1024;
      cfg_r.origin_x_cells  <= 16'sd23;
      cfg_r.origin_y_cells  <= 16'sd47;
    end else if (wr_en) begin
      case (widx)
        REG_RANGE_LIMIT: cfg_r.range_limit     <= pwdata[15:0];
        REG_ANGLE_START: cfg_r.angle_start     <= pwdata[15:0];
        REG_ANGLE_STEP:  cfg_r.angle_step      <= pwdata[15:0];
        REG_CELLS_PER_M: cfg_r.cells_per_metre <= pwdata[15:0];
        REG_ORIGIN_X:    cfg_r.origin_x_cells  <= pwdata[15:0];
        REG_ORIGIN_Y:    cfg_r.origin_y_cells  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (widx)
      REG_RANGE_LIMIT: prdata = {16'd0, cfg_r.range_limit};
      REG_ANGLE_START: prdata = {16'd0, cfg_r.angle_start};
      REG_ANGLE_STEP:  prdata = {16'd0, cfg_r.angle_step};
      REG_CELLS_PER_M: prdata = {16'd0, cfg_r.cells_per_metre};
      REG_ORIGIN_X:    prdata = {16'd0, cfg_r.origin_x_cells};
      REG_ORIGIN_Y:    prdata = {16'd0, cfg_r.origin_y_cells};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hw/rtl/srgc_cordic_step.sv]
// One CORDIC rotation step, reused for every iteration.
`timescale 1ns / 1ps
`default_nettype none

module srgc_cordic_step (
  input  wire logic signed [srgc_pkg::DP_W-1:0] x_in,
  input  wire logic signed [srgc_pkg::DP_W-1:0] y_in,
  input  wire logic signed [srgc_pkg::Z_W-1:0]  z_in,
  input  wire logic [srgc_pkg::ITER_W-1:0]      iter,
  output logic signed [srgc_pkg::DP_W-1:0]      x_out,
  output logic signed [srgc_pkg::DP_W-1:0]      y_out,
  output logic signed [srgc_pkg::Z_W-1:0]       z_out
);
  import srgc_pkg::*;

  logic signed [DP_W-1:0] dx;
  logic signed [DP_W-1:0] dy;
  logic signed [Z_W-1:0]  da;

  // Floor shifts of the cross terms
  assign dx = y_in >>> iter;
  assign dy = x_in >>> iter;
  assign da = atan_val(iter);

  // Rotate toward zero residual angle
  always_comb begin
    if (!z_in[Z_W-1]) begin
      x_out = x_in - dx;
      y_out = y_in + dy;
      z_out = z_in - da;
    end else begin
      x_out = x_in + dx;
      y_out = y_in - dy;
      z_out = z_in + da;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/srgc_core.sv]
// Sequencer with shared multiplier and CORDIC step for one ray at a time.
`timescale 1ns / 1ps
`default_nettype none

module srgc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire srgc_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire srgc_pkg::ray_t   in_ray,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output srgc_pkg::res_t        res
);
  import srgc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ROT  = 6'b000100,
    S_FIN1 = 6'b001000,
    S_FIN2 = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ITER_W-1:0]      step_r, step_nxt;
  ray_t                   ray_r;
  logic                   valid_r;
  logic [15:0]            theta_r;
  logic [31:0]            p_r;
  logic [R0_W-1:0]        r0_r;
  logic [8:0]             class_r;
  logic signed [DP_W-1:0] x_r;
  logic signed [DP_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;
  logic signed [15:0]     cx_r;
  logic signed [15:0]     cy_r;

  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_P_W-1:0]     prod;
  logic [15:0]            theta_off;
  logic [1:0]             quad;
  logic [15:0]            phi;
  logic signed [DP_W-1:0] r0_ext;
  logic signed [DP_W-1:0] xs_out;
  logic signed [DP_W-1:0] ys_out;
  logic signed [Z_W-1:0]  zs_out;
  logic signed [DP_W-1:0] org_x;
  logic signed [DP_W-1:0] org_y;
  logic                   in_fire;
  logic                   in_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign in_ok    = (in_ray.distance > HALF_METRE) && (in_ray.distance < cfg.range_limit);

  // Shared multiplier: angle, scaled range, gain correction, intensity class
  always_comb begin
    case (step_r[1:0])
      2'd0:    begin mul_a = MUL_A_W'(ray_r.ray_index); mul_b = cfg.angle_step;      end
      2'd1:    begin mul_a = MUL_A_W'(ray_r.distance);  mul_b = cfg.cells_per_metre; end
      2'd2:    begin mul_a = p_r;                       mul_b = INV_GAIN;            end
      default: begin mul_a = MUL_A_W'(ray_r.intensity[15:3]); mul_b = CLASS_MUL;   end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Quadrant fold of the ray angle
  assign theta_off = theta_r + 16'h2000;
  assign quad      = theta_off[15:14];
  assign phi       = theta_r - {quad, 14'd0};
  assign r0_ext    = DP_W'(r0_r);

  // Origins in the fixed-point grid format
  assign org_x = {{(DP_W-16-CELL_FB){cfg.origin_x_cells[15]}}, cfg.origin_x_cells,
                  {CELL_FB{1'b0}}};
  assign org_y = {{(DP_W-16-CELL_FB){cfg.origin_y_cells[15]}}, cfg.origin_y_cells,
                  {CELL_FB{1'b0}}};

  srgc_cordic_step u_step (
    .x_in  (x_r),
    .y_in  (y_r),
    .z_in  (z_r),
    .iter  (step_r),
    .x_out (xs_out),
    .y_out (ys_out),
    .z_out (zs_out)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_fire) begin
          state_nxt = in_ok ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        step_nxt = step_r + 1'b1;
        if (step_r[1:0] == 2'd3) begin
          step_nxt  = '0;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        step_nxt = step_r + 1'b1;
        if (step_r == ITER_W'(CORDIC_ITERS - 1)) begin
          state_nxt = S_FIN1;
        end
      end
      S_FIN1: state_nxt = S_FIN2;
      S_FIN2: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ray_r   <= in_ray;
          valid_r <= in_ok;
        end
      end
      S_MUL: begin
        case (step_r[1:0])
          2'd0: theta_r <= cfg.angle_start + prod[15:0];
          2'd1: p_r     <= prod[31:0];
          2'd2: r0_r    <= prod[MUL_P_W-1:8];
          default: begin
            class_r <= prod[CLASS_SHIFT+8:CLASS_SHIFT];
            z_r     <= {phi, {(Z_W-16){1'b0}}};
            case (quad)
              2'd0:    begin x_r <= r0_ext;  y_r <= '0;      end
              2'd1:    begin x_r <= '0;      y_r <= r0_ext;  end
              2'd2:    begin x_r <= -r0_ext; y_r <= '0;      end
              default: begin x_r <= '0;      y_r <= -r0_ext; end
            endcase
          end
        endcase
      end
      S_ROT: begin
        x_r <= xs_out;
        y_r <= ys_out;
        z_r <= zs_out;
      end
      S_FIN1: begin
        x_r <= x_r + org_x;
        y_r <= org_y - y_r;
      end
      S_FIN2: begin
        cx_r <= to_cell(x_r);
        cy_r <= to_cell(y_r);
      end
      default: ;
    endcase
  end

  // Result word; invalid rays carry zero fields
  assign res_valid           = (state_r == S_DONE);
  assign res.point_valid     = valid_r;
  assign res.cell_x          = valid_r ? cx_r : 16'sd0;
  assign res.cell_y          = valid_r ? cy_r : 16'sd0;
  assign res.intensity_class = valid_r ? class_r : 9'd0;
  assign res.near_hit        = valid_r && (ray_r.distance < THREE_Q_METRE);
  assign res.scan_done       = ray_r.scan_last;

endmodule

`default_nettype wire

[hw/rtl/scan_ray_to_grid_cell.sv]
// Top level: scan ray to grid cell conversion with stream ports and APB registers.
// Usage:
//   Input words carry one laser ray each (index, range in Q8.8 metres,
//   intensity); in_tlast marks the final ray of a scan. Each ray gives
//   exactly one output word: valid flag, grid cell x and y, intensity
//   class and the scan's sticky near-range flag; out_tlast echoes in_tlast.
//   A valid ray goes from acceptance to out_tvalid through four passes
//   through the shared multiplier, sixteen passes through the CORDIC step,
//   the offset and saturation steps and then the output register.
//   An invalid ray skips the multiplier and the rotation and goes through
//   the done state into the output register. in_tready is high only while
//   the sequencer is idle, so a new ray is taken only after the last one
//   has been handed to the output register.
//   The output register holds a finished word while out_tready is low; the
//   sequencer then waits with the next result and takes no new ray.
//   Reset (rst_n low, synchronous) empties the output register, clears the
//   near-range flag and restores register defaults. Registers must be written
//   over the cfg_ port only while no ray is in flight; not enforced by the block.
`timescale 1ns / 1ps
`default_nettype none

module scan_ray_to_grid_cell (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input rays
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // ray_index[10:0], distance[26:11], intensity[42:27]
  input  wire logic        in_tlast,
  // Grid cells
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // cell_x[15:0], cell_y[31:16], intensity_class[40:32]
  output logic [1:0]       out_tuser,  // point_valid[0], too_close_seen[1]
  output logic             out_tlast,
  // Register access
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import srgc_pkg::*;

  cfg_t        cfg;
  ray_t        in_ray;
  res_t        res;
  logic        res_valid;
  logic        res_ready;
  logic        close_hit_r;
  logic        near_flag;
  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic        out_tlast_r;

  assign cfg_pready = 1'b1;

  srgc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Unpack input word
  assign in_ray.ray_index = in_tdata[10:0];
  assign in_ray.distance  = in_tdata[26:11];
  assign in_ray.intensity = in_tdata[42:27];
  assign in_ray.scan_last = in_tlast;

  srgc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ray    (in_ray),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register takes a word when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;
  assign near_flag = close_hit_r || res.near_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      close_hit_r  <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_tvalid_r <= 1'b1;
        close_hit_r  <= res.scan_done ? 1'b0 : near_flag;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {7'd0, res.intensity_class, res.cell_y, res.cell_x};
      out_tuser_r <= {near_flag, res.point_valid};
      out_tlast_r <= res.scan_done;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sequencer accepted a ray while busy");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[40:0] == 41'd0))
    else $error("invalid ray carries non-zero cell fields");

  a_flag_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && res.scan_done) |=> !close_hit_r)
    else $error("near-range flag not cleared after end of scan");

  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && !res.scan_done && close_hit_r) |=> close_hit_r)
    else $error("near-range flag dropped within a scan");

endmodule

`default_nettype wire
